### rtl/scba_pkg.sv
package scba_pkg;

  localparam int NUM_CLASSES_DEF      = 4;
  localparam int MAX_REGIONS_DEF      = 8;
  localparam int SLOTS_PER_REGION_DEF = 256;
  localparam int REGISTRY_DEPTH_DEF   = 64;

  localparam int CLASS_REGS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES_USE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REGIONS_PER = 3'd6;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIZE    = 3'd1,
    ST_TOO_MANY    = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_BAD_EXTENT  = 3'd4,
    ST_REG_FULL    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG_SCAN,
    S_CLASS_SCAN,
    S_REGION_SCAN,
    S_OPEN,
    S_POP_RD,
    S_POP_WAIT,
    S_GRANT,
    S_FREE_REGION,
    S_FREE_PUSH,
    S_DONE
  } state_t;

endpackage

### rtl/size_class_block_allocator_core.sv
// One shared compare/add unit walks the registry, the four class registers and the regions of
// one class, one entry per cycle. Throughput: one item at a time; busy stays high until
// out_valid has pulsed. Results are shown for one cycle and the receiver cannot stall. Reset
// (rst_n low, synchronous) clears the handle counter, registry valid bits, region open bits and
// the per-class next region numbers, and restores the configuration.
module size_class_block_allocator_core
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
  parameter int MAX_REGIONS      = MAX_REGIONS_DEF,
  parameter int SLOTS_PER_REGION = SLOTS_PER_REGION_DEF,
  parameter int REGISTRY_DEPTH   = REGISTRY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  logic [47:0]           in_request_size,
  input  logic [31:0]           in_handle_in,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [31:0]           out_handle_out,
  output logic                  out_is_dedicated,
  output logic [1:0]            out_class_index,
  output logic [15:0]           out_region_number,
  output logic [39:0]           out_block_offset,
  output logic [47:0]           out_granted_bytes
);

  localparam int NSLOT  = NUM_CLASSES * MAX_REGIONS;
  localparam int SL_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int RG_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CL_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int RE_W   = $clog2(REGISTRY_DEPTH);
  localparam int SP_W   = $clog2(SLOTS_PER_REGION);
  localparam int CNT_W  = $clog2(SLOTS_PER_REGION + 1);
  localparam int FA_W   = SL_W + SP_W;
  localparam int NCL_MAX = (NUM_CLASSES < CLASS_REGS) ? NUM_CLASSES : CLASS_REGS;
  localparam int ENT_W  = 32 + 1 + 2 + 16 + 40;

  // Configuration.
  logic [31:0] class_size_r [CLASS_REGS];
  logic [2:0]  classes_in_use_r;
  logic [39:0] region_limit_r;
  logic [3:0]  regions_per_r;

  // Registry: valid bits in flops, the entry bodies in a memory with a registered read.
  logic               ent_valid_r [REGISTRY_DEPTH];
  logic [ENT_W-1:0]   ent_mem [REGISTRY_DEPTH];
  logic [ENT_W-1:0]   ent_rdata_r;
  logic               ent_we;
  logic [ENT_W-1:0]   ent_wdata;
  logic [RE_W-1:0]    ent_raddr;
  logic [31:0]        rd_handle;
  logic               rd_ded;
  logic [1:0]         rd_class;
  logic [15:0]        rd_region;
  logic [39:0]        rd_off;

  // Regions.
  logic               reg_open_r [NSLOT];
  logic [15:0]        reg_id_r [NSLOT];
  logic [39:0]        reg_bump_r [NSLOT];
  logic [CNT_W-1:0]   reg_live_r [NSLOT];
  logic [CNT_W-1:0]   reg_freed_r [NSLOT];
  logic [15:0]        next_id_r [NUM_CLASSES];

  logic [31:0]        id_counter_r;

  state_t             state_r, state_nxt;
  logic               op_r;
  logic [47:0]        size_r;
  logic [31:0]        hin_r;
  logic [RE_W:0]      idx_r;     // scan counter, wide enough to hold the depth
  logic [RE_W-1:0]    ent_r;     // chosen registry entry
  logic               ent_found_r;
  logic               hit_ded_r;
  logic [1:0]         hit_class_r;
  logic [15:0]        hit_region_r;
  logic [39:0]        hit_off_r;
  logic [CL_W-1:0]    cls_r;
  logic               cls_found_r;
  logic [SL_W-1:0]    slot_r;
  logic               slot_found_r;
  logic               free_seen_r;
  logic [SL_W-1:0]    free_slot_r;
  logic [4:0]         open_cnt_r;
  logic [31:0]        bs_r;
  logic [2:0]         status_r;
  logic [39:0]        off_r;
  logic [15:0]        rid_r;
  logic [31:0]        hout_r;
  logic               ded_r;

  logic               fm_we;
  logic [FA_W-1:0]    fm_waddr, fm_raddr;
  logic [39:0]        fm_rdata;

  scba_freed_mem #(.DEPTH(NSLOT * SLOTS_PER_REGION), .ADDR_W(FA_W)) u_freed (
    .clk(clk), .wr_en(fm_we), .wr_addr(fm_waddr), .wr_data(hit_off_r),
    .rd_addr(fm_raddr), .rd_data(fm_rdata)
  );

  logic [2:0] ncls;
  logic [4:0] rlim;
  always_comb begin
    ncls = (classes_in_use_r > 3'(NCL_MAX)) ? 3'(NCL_MAX) : classes_in_use_r;
    rlim = ({1'b0, regions_per_r} > 5'(MAX_REGIONS)) ? 5'(MAX_REGIONS)
                                                     : {1'b0, regions_per_r};
  end

  // Shared scan unit: one element of the current scan per cycle.
  logic [RG_W-1:0] ridx;
  logic [SL_W-1:0] scan_slot;
  logic            usable;
  logic [40:0]     bump_sum;
  assign ridx      = idx_r[RG_W-1:0];
  assign scan_slot = SL_W'(cls_r * MAX_REGIONS) + SL_W'(ridx);
  assign bump_sum  = {1'b0, reg_bump_r[scan_slot]} + 41'(bs_r);
  assign usable = (reg_freed_r[scan_slot] != '0) ||
                  ((bump_sum <= {1'b0, region_limit_r}) &&
                   ((reg_live_r[scan_slot] + reg_freed_r[scan_slot]) <
                    CNT_W'(SLOTS_PER_REGION)));

  logic [SL_W-1:0] fr_slot;
  assign fr_slot = SL_W'(hit_class_r * MAX_REGIONS) + SL_W'(ridx);

  // The registry read is registered, so its data belongs to the entry before the scan counter.
  logic [RE_W-1:0] scan_ent;
  assign scan_ent  = RE_W'(idx_r - 1'b1);
  assign ent_raddr = idx_r[RE_W-1:0];
  assign {rd_handle, rd_ded, rd_class, rd_region, rd_off} = ent_rdata_r;

  logic [39:0] grant_off;
  assign grant_off = (reg_freed_r[slot_r] != '0) ? fm_rdata : reg_bump_r[slot_r];
  assign ent_we    = (state_r == S_GRANT) && (status_r == ST_OK);
  assign ent_wdata = {hout_r, ded_r, ded_r ? 2'd0 : 2'(cls_r),
                      ded_r ? 16'd0 : reg_id_r[slot_r], ded_r ? 40'd0 : grant_off};

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_r] <= ent_wdata;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  assign busy     = (state_r != S_IDLE);
  assign fm_raddr = {slot_r, SP_W'(reg_freed_r[slot_r] - 1'b1)};
  assign fm_waddr = {slot_r, SP_W'(reg_freed_r[slot_r])};
  assign fm_we    = (state_r == S_FREE_PUSH) &&
                    (reg_freed_r[slot_r] < CNT_W'(SLOTS_PER_REGION));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_REG_SCAN;
      S_REG_SCAN: begin
        if (idx_r == (RE_W+1)'(REGISTRY_DEPTH)) begin
          state_nxt = op_r ? S_FREE_REGION : S_CLASS_SCAN;
        end
      end
      S_CLASS_SCAN: if (idx_r == (RE_W+1)'(CLASS_REGS - 1)) state_nxt = S_REGION_SCAN;
      S_REGION_SCAN: if (idx_r == (RE_W+1)'(MAX_REGIONS - 1)) state_nxt = S_OPEN;
      S_OPEN: state_nxt = S_POP_RD;
      S_POP_RD: state_nxt = S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_GRANT;
      S_GRANT: state_nxt = S_DONE;
      S_FREE_REGION: if (idx_r == (RE_W+1)'(MAX_REGIONS - 1)) state_nxt = S_FREE_PUSH;
      S_FREE_PUSH: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid         = (state_r == S_DONE);
    out_status        = status_r;
    out_handle_out    = hout_r;
    out_is_dedicated  = ded_r;
    out_class_index   = 2'(cls_r);
    out_region_number = rid_r;
    out_block_offset  = off_r;
    out_granted_bytes = ded_r ? size_r : 48'(bs_r);
    if (status_r != ST_OK || op_r) begin
      out_handle_out = '0; out_is_dedicated = 1'b0; out_class_index = '0;
      out_region_number = '0; out_block_offset = '0; out_granted_bytes = '0;
    end else if (ded_r) begin
      out_class_index = '0; out_region_number = '0; out_block_offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      class_size_r[0] <= 32'd4096;
      class_size_r[1] <= 32'd65536;
      class_size_r[2] <= 32'd1048576;
      class_size_r[3] <= 32'd16777216;
      classes_in_use_r <= 3'd4;
      region_limit_r <= 40'd1073741824;
      regions_per_r <= 4'd8;
      id_counter_r <= '0;
      for (int i = 0; i < REGISTRY_DEPTH; i++) ent_valid_r[i] <= 1'b0;
      for (int i = 0; i < NSLOT; i++) reg_open_r[i] <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) next_id_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index <= CFG_CLASS_3) class_size_r[cfg_index[1:0]] <= cfg_data[31:0];
        else if (cfg_index == CFG_CLASSES_USE) classes_in_use_r <= cfg_data[2:0];
        else if (cfg_index == CFG_REGION_LIM) region_limit_r <= cfg_data;
        else if (cfg_index == CFG_REGIONS_PER) regions_per_r <= cfg_data[3:0];
      end
      unique case (state_r)
        S_IDLE: begin
          op_r <= in_opcode; size_r <= in_request_size; hin_r <= in_handle_in;
          idx_r <= '0; ent_found_r <= 1'b0; cls_found_r <= 1'b0;
          slot_found_r <= 1'b0; free_seen_r <= 1'b0; open_cnt_r <= '0;
          status_r <= ST_OK; ded_r <= 1'b0; off_r <= '0; rid_r <= '0;
          hout_r <= '0; cls_r <= '0; bs_r <= '0;
        end
        S_REG_SCAN: begin
          if (idx_r != '0 && !ent_found_r &&
              (op_r ? (ent_valid_r[scan_ent] && rd_handle == hin_r)
                    : !ent_valid_r[scan_ent])) begin
            ent_found_r <= 1'b1;
            ent_r <= scan_ent;
            hit_ded_r <= rd_ded;
            hit_class_r <= rd_class;
            hit_region_r <= rd_region;
            hit_off_r <= rd_off;
          end
          idx_r <= (idx_r == (RE_W+1)'(REGISTRY_DEPTH)) ? '0 : idx_r + 1'b1;
        end
        S_CLASS_SCAN: begin
          if (!cls_found_r && idx_r < (RE_W+1)'(ncls) &&
              48'(class_size_r[idx_r[1:0]]) >= size_r) begin
            cls_found_r <= 1'b1;
            cls_r <= CL_W'(idx_r);
            bs_r <= class_size_r[idx_r[1:0]];
          end
          idx_r <= (idx_r == (RE_W+1)'(CLASS_REGS - 1)) ? '0 : idx_r + 1'b1;
        end
        S_REGION_SCAN: begin
          if (reg_open_r[scan_slot]) begin
            open_cnt_r <= open_cnt_r + 1'b1;
            if (usable && (!slot_found_r || reg_id_r[scan_slot] < reg_id_r[slot_r])) begin
              slot_found_r <= 1'b1;
              slot_r <= scan_slot;
            end
          end else if (!free_seen_r) begin
            free_seen_r <= 1'b1;
            free_slot_r <= scan_slot;
          end
          idx_r <= (idx_r == (RE_W+1)'(MAX_REGIONS - 1)) ? '0 : idx_r + 1'b1;
        end
        S_OPEN: begin
          // Decide the outcome of an allocate, take a handle and open a region if needed; S_GRANT commits the grant.
          if (size_r == '0) status_r <= ST_BAD_SIZE;
          else if (!ent_found_r) status_r <= ST_REG_FULL;
          else begin
            hout_r <= id_counter_r;
            id_counter_r <= id_counter_r + 1'b1;
            if (!cls_found_r) begin
              ded_r <= 1'b1;
            end else if (!slot_found_r) begin
              if (open_cnt_r >= rlim || !free_seen_r) status_r <= ST_TOO_MANY;
              else begin
                slot_r <= free_slot_r;
                reg_open_r[free_slot_r] <= 1'b1;
                reg_id_r[free_slot_r] <= next_id_r[cls_r];
                next_id_r[cls_r] <= next_id_r[cls_r] + 1'b1;
                reg_bump_r[free_slot_r] <= '0;
                reg_live_r[free_slot_r] <= '0;
                reg_freed_r[free_slot_r] <= '0;
              end
            end
          end
        end
        S_POP_RD, S_POP_WAIT: ;
        S_GRANT: begin
          if (status_r == ST_OK) begin
            ent_valid_r[ent_r] <= 1'b1;
            if (!ded_r) begin
              rid_r <= reg_id_r[slot_r];
              off_r <= grant_off;
              reg_live_r[slot_r] <= reg_live_r[slot_r] + 1'b1;
              if (reg_freed_r[slot_r] != '0) begin
                reg_freed_r[slot_r] <= reg_freed_r[slot_r] - 1'b1;
              end else begin
                reg_bump_r[slot_r] <= reg_bump_r[slot_r] + 40'(bs_r);
              end
            end
          end
        end
        S_FREE_REGION: begin
          if (ent_found_r && !slot_found_r && reg_open_r[fr_slot] &&
              reg_id_r[fr_slot] == hit_region_r) begin
            slot_found_r <= 1'b1;
            slot_r <= fr_slot;
          end
          idx_r <= (idx_r == (RE_W+1)'(MAX_REGIONS - 1)) ? '0 : idx_r + 1'b1;
        end
        S_FREE_PUSH: begin
          if (!ent_found_r) status_r <= ST_DOUBLE_FREE;
          else begin
            ent_valid_r[ent_r] <= 1'b0;
            if (!hit_ded_r) begin
              if (!slot_found_r || reg_live_r[slot_r] == '0) status_r <= ST_BAD_EXTENT;
              else begin
                if (reg_freed_r[slot_r] < CNT_W'(SLOTS_PER_REGION))
                  reg_freed_r[slot_r] <= reg_freed_r[slot_r] + 1'b1;
                reg_live_r[slot_r] <= reg_live_r[slot_r] - 1'b1;
                if (reg_live_r[slot_r] == CNT_W'(1)) reg_open_r[slot_r] <= 1'b0;
              end
            end
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_GRANT || $past(state_r) == S_FREE_PUSH))
    else $error("result without finished work");
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result shown twice");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block not idle after transfer");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");
`endif

endmodule

### rtl/scba_freed_mem.sv
module scba_freed_mem
  import scba_pkg::*;
#(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [39:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [39:0]       rd_data
);

  logic [39:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
